/* sv/lmrf_pkg.sv */
// Shared widths, defaults and types for the lane marking row filter.
package lmrf_pkg;

  localparam int PIX_W = 8;
  localparam int OFF_W = 5;

  localparam int DEF_MAX_OFFSET     = 31;
  localparam int DEF_MAX_ROW_LENGTH = 2048;

  localparam logic [OFF_W-1:0] TAP_RESET = 5'd4;

  typedef struct packed {
    logic [OFF_W-1:0] off;
    logic [OFF_W:0]   off2;
  } lmrf_tap_sel_t;

endpackage

/* sv/lmrf_stream_if.sv */
// Valid/ready channel interfaces for pixels in and marks out.
interface lmrf_pix_if;
  import lmrf_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             row_end;

  modport source (output valid, pixel, row_end, input ready);
  modport sink   (input valid, pixel, row_end, output ready);
endinterface

interface lmrf_res_if;
  logic valid;
  logic ready;
  logic mark;
  logic row_last;

  modport source (output valid, mark, row_last, input ready);
  modport sink   (input valid, mark, row_last, output ready);
endinterface

/* sv/lane_marking_row_filter_core.sv */
// Lane marking row filter: local threshold on a pixel window chain, then 1x3 opening.
//
// Pixels enter on pix_i (valid/ready), one gray level per transfer, row_end on the
// last pixel of a row. Results leave on res_o, one mark per column in column
// order, row_last on the last column of each row. cfg_we_i/cfg_wdata_i set the
// tap offset; it is sampled on the first pixel of each row (reset value 4).
//
// Throughput is one pixel per cycle within a row: the window is a chain of pixel
// cells that shifts on each transfer, and the opening stage emits one result per
// cycle. With an empty mark queue the mark for column c leaves via the stage-1
// registers, the mark queue and the result register once pixel c+offset+2 is
// taken. On a row end the remaining offset+3 results (fewer for short rows) are
// flushed one per cycle while the next row's pixels are already being taken.
// The row end token is popped without a result, so with rows sent back to back
// pix_i.ready drops once per row once the mark queue has filled.
// A stalled receiver holds the result register; the small mark queue then
// fills and pix_i.ready drops. Reset clears all control state but last_q and
// needs no clearing pass; pixel cells are not reset.
module lane_marking_row_filter_core #(
  parameter int MAX_OFFSET     = lmrf_pkg::DEF_MAX_OFFSET,
  parameter int MAX_ROW_LENGTH = lmrf_pkg::DEF_MAX_ROW_LENGTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  lmrf_pix_if.sink                     pix_i,
  lmrf_res_if.source                   res_o,
  input  logic                         cfg_we_i,
  input  logic [lmrf_pkg::OFF_W-1:0]   cfg_wdata_i
);
  import lmrf_pkg::*;

  localparam int WIN_CELLS = 2 * MAX_OFFSET;
  localparam int COL_W     = $clog2(MAX_ROW_LENGTH);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(MAX_ROW_LENGTH - 1);
  localparam logic [OFF_W-1:0] OFF_CAP  = OFF_W'(MAX_OFFSET);

  logic [OFF_W-1:0] tap_q;
  logic [OFF_W-1:0] row_off_q;
  logic [COL_W-1:0] col_q;

  logic [OFF_W-1:0] off_tap, off_cur;
  lmrf_tap_sel_t    sel;
  logic             accept, at_end, ge_off, ge_2off, tok_space;

  logic [PIX_W-1:0] chain [WIN_CELLS-1];
  logic [PIX_W-1:0] p_tap [WIN_CELLS];
  logic [PIX_W-1:0] l_tap [WIN_CELLS];
  logic [PIX_W-1:0] p_or, l_or;

  logic             s1_valid_q;
  logic [PIX_W-1:0] s1_r_q, s1_p_q, s1_l_q;
  logic             s1_end_q, s1_mk_q, s1_calc_q;
  logic [COL_W-1:0] s1_col_q;

  logic signed [PIX_W+4:0] a1, a2, dlr, adiff, dsum, p_s;
  logic             mark_bit;
  logic             tok_valid;
  logic [COL_W-1:0] tok_data;

  assign off_tap  = (tap_q > OFF_CAP) ? OFF_CAP : tap_q;
  assign off_cur  = (col_q == '0) ? off_tap : row_off_q;
  assign sel.off  = off_cur;
  assign sel.off2 = {off_cur, 1'b0};
  assign at_end   = pix_i.row_end || (col_q == LAST_COL);
  assign ge_off   = (col_q >= COL_W'(off_cur));
  assign ge_2off  = (col_q >= COL_W'(sel.off2));
  assign accept   = pix_i.valid && pix_i.ready;
  assign pix_i.ready = tok_space;

  for (genvar k = 0; k < WIN_CELLS; k++) begin : g_cell
    if (k == 0) begin : g_head
      lmrf_cell #(.IDX(k)) u_cell (
        .clk_i   (clk_i),
        .shift_i (accept),
        .d_i     (pix_i.pixel),
        .sel_i   (sel),
        .q_o     (chain[k]),
        .p_tap_o (p_tap[k]),
        .l_tap_o (l_tap[k])
      );
    end else if (k == WIN_CELLS - 1) begin : g_tail
      lmrf_cell #(.IDX(k)) u_cell (
        .clk_i   (clk_i),
        .shift_i (accept),
        .d_i     (chain[k-1]),
        .sel_i   (sel),
        .q_o     (),
        .p_tap_o (p_tap[k]),
        .l_tap_o (l_tap[k])
      );
    end else begin : g_mid
      lmrf_cell #(.IDX(k)) u_cell (
        .clk_i   (clk_i),
        .shift_i (accept),
        .d_i     (chain[k-1]),
        .sel_i   (sel),
        .q_o     (chain[k]),
        .p_tap_o (p_tap[k]),
        .l_tap_o (l_tap[k])
      );
    end
  end

  always_comb begin
    p_or = '0;
    l_or = '0;
    for (int k = 0; k < WIN_CELLS; k++) begin
      p_or = p_or | p_tap[k];
      l_or = l_or | l_tap[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q      <= TAP_RESET;
      row_off_q  <= TAP_RESET;
      col_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tap_q <= cfg_wdata_i;
      end
      s1_valid_q <= accept;
      if (accept) begin
        row_off_q <= off_cur;
        col_q     <= at_end ? '0 : col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_r_q    <= pix_i.pixel;
      s1_p_q    <= p_or;
      s1_l_q    <= l_or;
      s1_end_q  <= at_end;
      s1_mk_q   <= ge_off && !at_end;
      s1_calc_q <= ge_2off;
      s1_col_q  <= col_q;
    end
  end

  always_comb begin
    p_s      = $signed({5'b00000, s1_p_q});
    a1       = p_s - $signed({5'b00000, s1_r_q});
    a2       = p_s - $signed({5'b00000, s1_l_q});
    dlr      = $signed({5'b00000, s1_l_q}) - $signed({5'b00000, s1_r_q});
    adiff    = (dlr < 0) ? -dlr : dlr;
    dsum     = a1 + a2 - adiff;
    mark_bit = s1_calc_q && (a1 > 0) && (a2 > 0) && ((dsum <<< 2) > p_s);
  end

  // end token carries the last column, mark token carries the raw mark
  assign tok_valid = s1_valid_q && (s1_end_q || s1_mk_q);
  assign tok_data  = s1_end_q ? s1_col_q : {{(COL_W-1){1'b0}}, mark_bit};

  lmrf_open #(.COL_W(COL_W)) u_open (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tok_valid),
    .tok_end_i   (s1_end_q),
    .tok_data_i  (tok_data),
    .tok_space_o (tok_space),
    .res_o       (res_o)
  );

endmodule

/* sv/lmrf_cell.sv */
// One pixel cell of the window chain, with its center and left tap drive.
module lmrf_cell #(
  parameter int IDX = 0
) (
  input  logic                         clk_i,
  input  logic                         shift_i,
  input  logic [lmrf_pkg::PIX_W-1:0]   d_i,
  input  lmrf_pkg::lmrf_tap_sel_t      sel_i,
  output logic [lmrf_pkg::PIX_W-1:0]   q_o,
  output logic [lmrf_pkg::PIX_W-1:0]   p_tap_o,
  output logic [lmrf_pkg::PIX_W-1:0]   l_tap_o
);
  import lmrf_pkg::*;

  localparam logic [OFF_W+1:0] POS = (OFF_W+2)'(IDX + 1);

  logic [PIX_W-1:0] pix_q;
  logic             p_hit;
  logic             l_hit;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      pix_q <= d_i;
    end
  end

  // cell k holds the pixel k+1 columns behind the one arriving now
  assign p_hit   = ({2'b00, sel_i.off} == POS);
  assign l_hit   = ({1'b0, sel_i.off2} == POS);
  assign q_o     = pix_q;
  assign p_tap_o = p_hit ? pix_q : '0;
  assign l_tap_o = l_hit ? pix_q : '0;

endmodule

/* sv/lmrf_open.sv */
// Raw mark queue, 1x3 opening with row end flush, and the result register.
module lmrf_open #(
  parameter int COL_W = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             tok_valid_i,
  input  logic             tok_end_i,
  input  logic [COL_W-1:0] tok_data_i,
  output logic             tok_space_o,
  lmrf_res_if.source       res_o
);
  import lmrf_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = PTR_W + 1;
  localparam logic [1:0] FILL_FULL = 2'd2;

  logic             fifo_end_q  [DEPTH];
  logic [COL_W-1:0] fifo_data_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic [4:0]       win_q, win_d;
  logic [1:0]       fill_q, fill_d;
  logic             flush_q, flush_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [COL_W-1:0] last_q, last_d;
  logic [1:0]       pre_q, pre_d;
  logic [1:0]       pc_q, pc_d;

  logic             out_valid_q;
  logic             out_mark_q;
  logic             out_last_q;

  logic             head_valid, head_end, head_mark;
  logic [COL_W-1:0] head_data;
  logic             slot, pop, do_push, push_bit, pre_take, start_flush, emit, row_done;
  logic [4:0]       win_push;
  logic [1:0]       pre_next, pc_next;

  function automatic logic open3(input logic [4:0] w);
    return (w[0] & w[1] & w[2]) | (w[1] & w[2] & w[3]) | (w[2] & w[3] & w[4]);
  endfunction

  // token queue
  always_ff @(posedge clk_i) begin
    if (tok_valid_i) begin
      fifo_end_q[wr_ptr_q]  <= tok_end_i;
      fifo_data_q[wr_ptr_q] <= tok_data_i;
    end
  end

  assign head_valid  = (cnt_q != '0);
  assign head_end    = fifo_end_q[rd_ptr_q];
  assign head_data   = fifo_data_q[rd_ptr_q];
  assign head_mark   = head_data[0];
  assign tok_space_o = (cnt_q <= CNT_W'(DEPTH - 2));
  assign slot        = !out_valid_q || res_o.ready;

  always_comb begin
    pop         = 1'b0;
    do_push     = 1'b0;
    push_bit    = 1'b0;
    pre_take    = 1'b0;
    start_flush = 1'b0;
    if (flush_q) begin
      do_push  = (fill_q == FILL_FULL) ? slot : 1'b1;
      // first two marks of the next row load while this row drains
      pre_take = head_valid && !head_end && (pc_q != FILL_FULL);
      pop      = pre_take;
    end else if (head_valid) begin
      if (head_end) begin
        start_flush = 1'b1;
        pop         = 1'b1;
      end else begin
        do_push  = (fill_q == FILL_FULL) ? slot : 1'b1;
        push_bit = head_mark;
        pop      = do_push;
      end
    end
    emit     = do_push && (fill_q == FILL_FULL);
    win_push = {win_q[3:0], push_bit};
    row_done = flush_q && emit && (col_q == last_q);
    pre_next = pre_take ? {pre_q[0], head_mark} : pre_q;
    pc_next  = pre_take ? pc_q + 2'd1 : pc_q;
  end

  always_comb begin
    cnt_d   = cnt_q + CNT_W'(tok_valid_i) - CNT_W'(pop);
    win_d   = win_q;
    fill_d  = fill_q;
    col_d   = col_q;
    flush_d = flush_q;
    last_d  = last_q;
    pre_d   = pre_next;
    pc_d    = pc_next;
    if (do_push) begin
      win_d = win_push;
      if (fill_q != FILL_FULL) begin
        fill_d = fill_q + 2'd1;
      end
    end
    if (emit) begin
      col_d = col_q + COL_W'(1);
    end
    if (start_flush) begin
      flush_d = 1'b1;
      last_d  = head_data;
    end
    if (row_done) begin
      flush_d = 1'b0;
      win_d   = {3'b000, pre_next};
      fill_d  = pc_next;
      col_d   = '0;
      pre_d   = '0;
      pc_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      cnt_q       <= '0;
      win_q       <= '0;
      fill_q      <= '0;
      flush_q     <= 1'b0;
      col_q       <= '0;
      pre_q       <= '0;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (tok_valid_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      cnt_q   <= cnt_d;
      win_q   <= win_d;
      fill_q  <= fill_d;
      flush_q <= flush_d;
      col_q   <= col_d;
      pre_q   <= pre_d;
      pc_q    <= pc_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    if (emit) begin
      out_mark_q <= open3(win_push);
      out_last_q <= row_done;
    end
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.mark     = out_mark_q;
  assign res_o.row_last = out_last_q;

endmodule

/* sv/lmrf_checker.sv */
// Port-level checks for the lane marking row filter, bound to the top level.
module lmrf_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_mark_i,
  input logic out_last_i
);

  logic [7:0] pending_q;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 8'(in_xfer) - 8'(out_xfer);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_mark_i) && $stable(out_last_i))
    else $error("result changed while stalled");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> pending_q != 8'd0)
    else $error("result without a pending column");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q == 8'd0 |-> in_ready_i)
    else $error("input blocked with nothing in flight");

endmodule

bind lane_marking_row_filter_core lmrf_checker u_lmrf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_i.valid),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_mark_i  (res_o.mark),
  .out_last_i  (res_o.row_last)
);

/* tb/lane_marking_row_filter_core_tb.sv */
// Self-checking testbench for the lane marking row filter core.
`timescale 1ns / 100ps

module lane_marking_row_filter_core_tb;
  import lmrf_pkg::*;

  localparam int WIN_DEPTH = 2 * DEF_MAX_OFFSET + 1;
  localparam int ROW_MAX   = DEF_MAX_ROW_LENGTH;

  typedef struct packed {
    logic mark;
    logic row_last;
  } mark_res_t;

  class lane_mark_checker;
    logic [OFF_W-1:0] tap = TAP_RESET;
    int               row_off = int'(TAP_RESET);
    logic [PIX_W-1:0] win[WIN_DEPTH];
    int               col;
    logic [4:0]       hist;
    int               pushed;
    mark_res_t        marks_due[$];
    int               errors, checked, marked, pixels, rows;

    function new();
      foreach (win[i]) win[i] = '0;
      col    = 0;
      hist   = '0;
      pushed = 0;
    endfunction

    function void push_raw(bit raw, bit at_end, int last_col);
      mark_res_t e;
      hist = {hist[3:0], raw};
      pushed++;
      if (pushed < 3) return;
      e.mark     = (&hist[2:0]) | (&hist[3:1]) | (&hist[4:2]);
      e.row_last = at_end && ((pushed - 3) == last_col);
      marks_due = {marks_due, e};
    endfunction

    function void take_pixel(logic [PIX_W-1:0] pix, logic re);
      int n, off, r, p, l, a1, a2, dif;
      bit at_end, raw;
      n      = col;
      at_end = re || (n >= ROW_MAX - 1);
      pixels++;
      if (n == 0) row_off = int'(tap);
      off = row_off;
      for (int i = WIN_DEPTH - 1; i > 0; i--) win[i] = win[i-1];
      win[0] = pix;
      if (n >= off) begin
        raw = 1'b0;
        if (n >= 2 * off && !at_end) begin
          r   = int'(win[0]);
          p   = int'(win[off]);
          l   = int'(win[2*off]);
          a1  = p - r;
          a2  = p - l;
          dif = (l > r) ? l - r : r - l;
          raw = (a1 > 0) && (a2 > 0) && (4 * (a1 + a2 - dif) > p);
        end
        push_raw(raw, at_end, n);
      end
      if (at_end) begin
        while (pushed < n + 3) push_raw(1'b0, at_end, n);
        col    = 0;
        hist   = '0;
        pushed = 0;
        rows++;
      end else begin
        col = n + 1;
      end
    endfunction

    function void check_mark(logic m, logic rl);
      mark_res_t e;
      if (marks_due.size() == 0) begin
        $display("%0t: unexpected result transfer: mark=%b row_last=%b", $time, m, rl);
        errors++;
        return;
      end
      e = marks_due.pop_front();
      checked++;
      if (m === 1'b1) marked++;
      if (m !== e.mark) begin
        $display("%0t: mark mismatch: expected %b, actual %b", $time, e.mark, m);
        errors++;
      end
      if (rl !== e.row_last) begin
        $display("%0t: row_last mismatch: expected %b, actual %b", $time, e.row_last, rl);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [OFF_W-1:0] cfg_wdata_i;
  bit               gaps_on, stalls_on;
  int               settings;

  lmrf_pix_if pix_if ();
  lmrf_res_if res_if ();

  lane_mark_checker chk = new();

  lane_marking_row_filter_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_i       (pix_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) chk.check_mark(res_if.mark, res_if.row_last);
      if (pix_if.valid && pix_if.ready) chk.take_pixel(pix_if.pixel, pix_if.row_end);
    end
  end

  // result backpressure
  initial begin
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stalls_on && $urandom_range(0, 5) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk_i);
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    #(20_000_000);
    $display("Timeout: %0d results still pending", chk.marks_due.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic re);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      pix_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    pix_if.valid   <= 1'b1;
    pix_if.pixel   <= pix;
    pix_if.row_end <= re;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // mostly striped rows (background plus bright bars of width 1..5), some pure noise
  task automatic send_row(input int len, input bit no_end);
    int bg, bar_left, bar_lvl;
    bit noise;
    logic [PIX_W-1:0] pix;
    noise    = ($urandom_range(0, 3) == 0);
    bg       = $urandom_range(0, 100);
    bar_left = 0;
    bar_lvl  = 0;
    for (int i = 0; i < len; i++) begin
      if (noise) begin
        pix = PIX_W'($urandom_range(0, 255));
      end else if (bar_left > 0) begin
        pix = PIX_W'(bar_lvl);
        bar_left--;
      end else if ($urandom_range(0, 5) == 0) begin
        bar_lvl  = $urandom_range(120, 255);
        bar_left = $urandom_range(0, 4);
        pix      = PIX_W'(bar_lvl);
      end else begin
        pix = PIX_W'(bg + $urandom_range(0, 15));
      end
      send_pixel(pix, (i == len - 1) && !no_end);
    end
  endtask

  task automatic drain();
    pix_if.valid <= 1'b0;
    while (chk.marks_due.size() != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic set_offset(input int off);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= OFF_W'(off);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    chk.tap = OFF_W'(off);
    settings++;
  endtask

  initial begin
    int offs[7];
    int sent, len;
    pix_if.valid   <= 1'b0;
    pix_if.pixel   <= '0;
    pix_if.row_end <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_wdata_i    <= '0;
    rst_ni         <= 1'b0;
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    settings  = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset offset: a 3-wide bar that survives, a 2-wide bar that is opened away
    for (int i = 0; i < 20; i++)
      send_pixel(((i >= 5 && i < 8) || (i >= 13 && i < 15)) ? 8'hFF : 8'h00, i == 19);
    // rows of one and two pixels
    send_pixel(8'hFF, 1'b1);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b1);
    drain();
    // offset zero marks nothing
    set_offset(0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h80, 1'b1);
    drain();

    offs = '{1, 31, $urandom_range(2, 8), 0, $urandom_range(1, 31), 4, 3};
    foreach (offs[p]) begin
      set_offset(offs[p]);
      gaps_on   = (p != 6) && ($urandom_range(0, 3) != 0);
      stalls_on = (p != 6) && ($urandom_range(0, 3) != 0);
      sent = 0;
      while (sent < 12) begin
        if ($urandom_range(0, 4) == 0) len = $urandom_range(1, 2 * offs[p] + 3);
        else len = 2 * offs[p] + 3 + $urandom_range(1, 6);
        send_row(len, 1'b0);
        sent += len;
      end
      drain();
    end

    $display("Sent %0d pixels in %0d rows over %0d offset settings (0, 1, 31 included);",
             chk.pixels, chk.rows, settings + 1);
    $display("%0d results checked, %0d of them marked.", chk.checked, chk.marked);
    if (chk.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* lane_marking_row_filter_core.f */
sv/lmrf_pkg.sv
sv/lmrf_stream_if.sv
sv/lmrf_cell.sv
sv/lmrf_open.sv
sv/lane_marking_row_filter_core.sv
sv/lmrf_checker.sv
tb/lane_marking_row_filter_core_tb.sv
